// ----- rtl/rfid_inventory_frame_dedup_defines.svh -----
// Assertion helpers shared by the dedup block.
`ifndef RFID_INVENTORY_FRAME_DEDUP_DEFINES_SVH
`define RFID_INVENTORY_FRAME_DEDUP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define RFDD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfdd assertion failed");

// Next-cycle implication, disabled while in reset
`define RFDD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfdd assertion failed");

`endif

// ----- rtl/rfdd_pkg.sv -----
package rfdd_pkg;

  localparam int MAX_TAGS    = 64;
  localparam int FRAME_BYTES = 24;
  localparam int EPC_FIRST   = 8;
  localparam int EPC_BYTES   = 12;
  localparam int END_POS     = 23;
  localparam int EPC_W       = 8 * EPC_BYTES;
  localparam int ADDR_W      = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
  localparam int CNT_W       = $clog2(MAX_TAGS + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0] HDR_START = 8'hBB;
  localparam logic [7:0] HDR_TYPE  = 8'h02;
  localparam logic [7:0] HDR_CMD   = 8'h22;
  localparam logic [7:0] END_MARK  = 8'h7E;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Command passed from the front end to the lookup engine
  typedef struct packed {
    logic             clr;
    logic [EPC_W-1:0] epc;
  } rfdd_cmd_t;

endpackage

// ----- rtl/rfid_inventory_frame_dedup.sv -----
// Inventory reply deduplicator.
// Input channel: one item per transfer, in_kind selects a received reply byte
// or a clear of the byte window and the tag list. in_stall rises only while
// the four-entry command queue between front end and lookup engine is full.
// Bytes are taken one per cycle unless stalled; the front end classifies each byte
// against the 24-byte window in the cycle it arrives and queues frames and clears.
// Output channel: one result per recognised frame, with the EPC, new/full
// flags, the store slot and the tag count after the frame.
// The lookup engine takes one queued command at a time. For a frame it reads
// one stored EPC a cycle from its single-port store, comparing each with the
// frame's EPC until a match or the last stored tag; a clear only zeroes the
// tag count.
// Reset (rst_n low, synchronous) zeroes the window, the tag count, the queue
// and the output valid flag; the tag store needs no clearing pass.
// A stalled result holds in the output register; the engine then waits, the
// queue fills, and only after four pending commands is the input stalled.
module rfid_inventory_frame_dedup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_new,
  output logic        out_table_full,
  output logic [5:0]  out_tag_index,
  output logic [31:0] out_epc_high,
  output logic [63:0] out_epc_low,
  output logic [6:0]  out_tag_count
);
  import rfdd_pkg::*;

  logic      acc, push, q_full, q_empty, q_pop;
  rfdd_cmd_t wr_cmd, rd_cmd;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  rfdd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_kind),
    .data_byte (in_data_byte),
    .push      (push),
    .cmd       (wr_cmd)
  );

  rfdd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  rfdd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (rd_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full),
    .out_tag_index  (out_tag_index),
    .out_epc_high   (out_epc_high),
    .out_epc_low    (out_epc_low),
    .out_tag_count  (out_tag_count)
  );

endmodule

// ----- rtl/rfdd_front.sv -----
module rfdd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic               kind,
  input  logic [7:0]         data_byte,
  output logic               push,
  output rfdd_pkg::rfdd_cmd_t cmd
);
  import rfdd_pkg::*;

  logic [7:0] win_r [FRAME_BYTES];
  logic [7:0] win_sh [FRAME_BYTES];
  logic       frame_hit;

  always_comb begin
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      win_sh[k] = win_r[k + 1];
    end
    win_sh[FRAME_BYTES - 1] = data_byte;
  end

  always_comb begin
    frame_hit = (win_sh[0] == HDR_START) && (win_sh[1] == HDR_TYPE) &&
                (win_sh[2] == HDR_CMD) && (win_sh[END_POS] == END_MARK);
    for (int k = 0; k < EPC_BYTES; k++) begin
      if (win_sh[EPC_FIRST + k] == END_MARK) begin
        frame_hit = 1'b0;
      end
    end
  end

  always_comb begin
    cmd.clr = (kind == KIND_CLEAR);
    for (int k = 0; k < EPC_BYTES; k++) begin
      cmd.epc[EPC_W - 1 - 8 * k -: 8] = win_sh[EPC_FIRST + k];
    end
  end

  assign push = acc && ((kind == KIND_CLEAR) || frame_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        win_r[k] <= 8'h00;
      end
    end else if (acc) begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
        win_r[k] <= (kind == KIND_CLEAR) ? 8'h00 : win_sh[k];
      end
    end
  end

endmodule

// ----- rtl/rfdd_queue.sv -----
module rfdd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rfdd_pkg::rfdd_cmd_t wr_cmd,
  output logic                full,
  input  logic                pop,
  output rfdd_pkg::rfdd_cmd_t rd_cmd,
  output logic                empty
);
  import rfdd_pkg::*;

  rfdd_cmd_t          ent_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, wp_nxt;
  logic [QPTR_W-1:0]  rp_r, rp_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= wr_cmd;
    end
  end

endmodule

// ----- rtl/rfdd_back.sv -----
`include "rfid_inventory_frame_dedup_defines.svh"

module rfdd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rfdd_pkg::rfdd_cmd_t q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_is_new,
  output logic                out_table_full,
  output logic [5:0]          out_tag_index,
  output logic [31:0]         out_epc_high,
  output logic [63:0]         out_epc_low,
  output logic [6:0]          out_tag_count
);
  import rfdd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_DONE = 3'b100
  } bst_t;

  bst_t              st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              cvld_r, cvld_nxt;
  logic [ADDR_W-1:0] cidx_r, cidx_nxt;
  logic [EPC_W-1:0]  epc_r, epc_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;
  logic              new_r, new_nxt;
  logic              full_r, full_nxt;

  logic [EPC_W-1:0]  mem [MAX_TAGS];
  logic [EPC_W-1:0]  rd_data_r;
  logic              rd_en, wr_en, issuing, hit, out_load;

  logic              ovld_r;
  logic              onew_r, ofull_r;
  logic [5:0]        oidx_r;
  logic [EPC_W-1:0]  oepc_r;
  logic [6:0]        ocnt_r;

  assign issuing  = (st_r == ST_SRCH) && (iss_r < cnt_r);
  assign hit      = cvld_r && (rd_data_r == epc_r);
  assign out_load = (st_r == ST_DONE) && (!ovld_r || !out_stall);
  assign q_pop    = (st_r == ST_IDLE) && !q_empty;

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    iss_nxt  = iss_r;
    cvld_nxt = 1'b0;
    cidx_nxt = cidx_r;
    epc_nxt  = epc_r;
    slot_nxt = slot_r;
    new_nxt  = new_r;
    full_nxt = full_r;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.clr) begin
            cnt_nxt = '0;
          end else begin
            epc_nxt = q_cmd.epc;
            iss_nxt = '0;
            st_nxt  = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        // Read one entry a cycle; compare the previous read meanwhile
        if (issuing && !hit) begin
          rd_en    = 1'b1;
          iss_nxt  = iss_r + 1'b1;
          cvld_nxt = 1'b1;
          cidx_nxt = iss_r[ADDR_W-1:0];
        end
        if (hit) begin
          new_nxt  = 1'b0;
          full_nxt = 1'b0;
          slot_nxt = cidx_r;
          st_nxt   = ST_DONE;
        end else if (!issuing) begin
          new_nxt = 1'b1;
          st_nxt  = ST_DONE;
          if (cnt_r == CNT_W'(MAX_TAGS)) begin
            full_nxt = 1'b1;
            slot_nxt = '0;
          end else begin
            full_nxt = 1'b0;
            slot_nxt = cnt_r[ADDR_W-1:0];
            wr_en    = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cnt_r  <= '0;
      iss_r  <= '0;
      cvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      iss_r  <= iss_nxt;
      cvld_r <= cvld_nxt;
      if (out_load) begin
        ovld_r <= 1'b1;
      end else if (!out_stall) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cidx_r <= cidx_nxt;
    epc_r  <= epc_nxt;
    slot_r <= slot_nxt;
    new_r  <= new_nxt;
    full_r <= full_nxt;
    if (out_load) begin
      onew_r  <= new_r;
      ofull_r <= full_r;
      oidx_r  <= 6'(slot_r);
      oepc_r  <= epc_r;
      ocnt_r  <= 7'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ADDR_W-1:0]] <= epc_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[iss_r[ADDR_W-1:0]];
    end
  end

  assign out_valid      = ovld_r;
  assign out_is_new     = onew_r;
  assign out_table_full = ofull_r;
  assign out_tag_index  = oidx_r;
  assign out_epc_high   = oepc_r[EPC_W-1 -: 32];
  assign out_epc_low    = oepc_r[63:0];
  assign out_tag_count  = ocnt_r;

  `RFDD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_TAGS))
  `RFDD_ASSERT_NOW(a_iss_bound, st_r == ST_SRCH, iss_r <= cnt_r)
  `RFDD_ASSERT_NOW(a_full_new, ovld_r && ofull_r, onew_r)
  `RFDD_ASSERT_NXT(a_append, wr_en, cnt_r == $past(cnt_r) + 1'b1)
  `RFDD_ASSERT_NXT(a_load_busy, out_load, st_r == ST_IDLE && ovld_r)

endmodule

// ----- dv/rfid_inventory_frame_dedup_test.sv -----
typedef struct packed {
  logic        is_new;
  logic        table_full;
  logic [5:0]  tag_index;
  logic [31:0] epc_high;
  logic [63:0] epc_low;
  logic [6:0]  tag_count;
} tag_report_t;

class tag_dedup_tracker;
  logic [7:0] window [rfdd_pkg::FRAME_BYTES];
  logic [rfdd_pkg::EPC_W-1:0] store_epc [rfdd_pkg::MAX_TAGS];
  int unsigned stored;
  tag_report_t pending_reports [$];
  int unsigned mismatches;

  function new();
    wipe();
    mismatches = 0;
  endfunction

  function void wipe();
    foreach (window[i]) window[i] = 8'h00;
    stored = 0;
  endfunction

  // Shift one accepted byte into the window and queue the report it causes; a clear wipes the window and tag list
  function void take_item(logic kind, logic [7:0] data);
    logic [rfdd_pkg::EPC_W-1:0] epc;
    logic framed;
    logic found;
    int unsigned slot;
    tag_report_t rep;
    if (kind == rfdd_pkg::KIND_CLEAR) begin
      wipe();
      return;
    end
    for (int i = 0; i < rfdd_pkg::FRAME_BYTES - 1; i++) window[i] = window[i + 1];
    window[rfdd_pkg::FRAME_BYTES - 1] = data;
    framed = (window[0] == rfdd_pkg::HDR_START) && (window[1] == rfdd_pkg::HDR_TYPE) &&
             (window[2] == rfdd_pkg::HDR_CMD) &&
             (window[rfdd_pkg::END_POS] == rfdd_pkg::END_MARK);
    epc = '0;
    for (int k = 0; k < rfdd_pkg::EPC_BYTES; k++) begin
      epc = {epc[rfdd_pkg::EPC_W-9:0], window[rfdd_pkg::EPC_FIRST + k]};
      if (window[rfdd_pkg::EPC_FIRST + k] == rfdd_pkg::END_MARK) framed = 1'b0;
    end
    if (!framed) return;
    found = 1'b0;
    slot = 0;
    for (int i = 0; i < stored; i++) begin
      if (!found && store_epc[i] == epc) begin
        found = 1'b1;
        slot = i;
      end
    end
    rep.is_new = !found;
    rep.table_full = 1'b0;
    if (!found) begin
      if (stored >= rfdd_pkg::MAX_TAGS) begin
        // drop the tag; slot carries no meaning here
        rep.table_full = 1'b1;
        slot = 0;
      end else begin
        slot = stored;
        store_epc[stored] = epc;
        stored++;
      end
    end
    rep.tag_index = slot[5:0];
    rep.epc_high = epc[95:64];
    rep.epc_low = epc[63:0];
    rep.tag_count = stored[6:0];
    pending_reports.push_back(rep);
  endfunction

  function void log_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s mismatch: expected %0h, got %0h", field, want, got);
  endfunction

  function void check_report(tag_report_t got);
    tag_report_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report: epc %h_%h count %0d", got.epc_high, got.epc_low,
                 got.tag_count);
      return;
    end
    want = pending_reports.pop_front();
    if (got.is_new !== want.is_new)
      log_mismatch("is_new", 64'(want.is_new), 64'(got.is_new));
    if (got.table_full !== want.table_full)
      log_mismatch("table_full", 64'(want.table_full), 64'(got.table_full));
    if (got.tag_index !== want.tag_index)
      log_mismatch("tag_index", 64'(want.tag_index), 64'(got.tag_index));
    if (got.epc_high !== want.epc_high)
      log_mismatch("epc_high", 64'(want.epc_high), 64'(got.epc_high));
    if (got.epc_low !== want.epc_low) log_mismatch("epc_low", want.epc_low, got.epc_low);
    if (got.tag_count !== want.tag_count)
      log_mismatch("tag_count", 64'(want.tag_count), 64'(got.tag_count));
  endfunction
endclass

module rfid_inventory_frame_dedup_test;
  import rfdd_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 650;
  localparam int FILL_AFTER   = 300;
  localparam int DRAIN_CYCLES = 80;

  typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_END, FLAW_MARK_IN_EPC} frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_BYTE;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_new;
  logic        out_table_full;
  logic [5:0]  out_tag_index;
  logic [31:0] out_epc_high;
  logic [63:0] out_epc_low;
  logic [6:0]  out_tag_count;

  tag_dedup_tracker tracker;
  logic [EPC_W-1:0] epc_pool [$];
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned item_count = 0;
  int unsigned fill_items = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;
  int run_left = 0;
  bit run_level = 1'b0;

  rfid_inventory_frame_dedup i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full),
    .out_tag_index  (out_tag_index),
    .out_epc_high   (out_epc_high),
    .out_epc_low    (out_epc_low),
    .out_tag_count  (out_tag_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_report({out_is_new, out_table_full, out_tag_index, out_epc_high,
                            out_epc_low, out_tag_count});
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_phase_left = $urandom_range(50, 300);
      end
      stall_phase_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          // alternate long holds with short open windows
          if (run_left == 0) begin
            run_level = !run_level;
            run_left = run_level ? $urandom_range(5, 25) : $urandom_range(1, 6);
          end
          run_left--;
          out_stall <= run_level;
        end
      endcase
    end
  end

  task automatic send_item(input logic kind, input logic [7:0] data);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= data;
    do @(posedge clk); while (in_stall);
    tracker.take_item(kind, data);
    burst_left--;
    item_count++;
  endtask

  task automatic send_frame(input logic [EPC_W-1:0] epc, input frame_flaw_t flaw,
                            input int len);
    logic [7:0] bytes [FRAME_BYTES];
    int spot;
    foreach (bytes[i]) bytes[i] = 8'($urandom_range(0, 255));
    bytes[0] = HDR_START;
    bytes[1] = HDR_TYPE;
    bytes[2] = HDR_CMD;
    for (int k = 0; k < EPC_BYTES; k++) bytes[EPC_FIRST + k] = epc[EPC_W - 8 * k - 1 -: 8];
    bytes[END_POS] = END_MARK;
    case (flaw)
      FLAW_HEADER: begin
        spot = $urandom_range(0, 2);
        bytes[spot] = bytes[spot] ^ 8'($urandom_range(1, 255));
      end
      FLAW_END: bytes[END_POS] = bytes[END_POS] ^ 8'($urandom_range(1, 255));
      FLAW_MARK_IN_EPC: bytes[EPC_FIRST + $urandom_range(0, EPC_BYTES - 1)] = END_MARK;
      default: ;
    endcase
    for (int i = 0; i < len; i++) send_item(KIND_BYTE, bytes[i]);
  endtask

  function automatic logic [EPC_W-1:0] clean_epc(logic [EPC_W-1:0] e);
    for (int k = 0; k < EPC_BYTES; k++)
      if (e[8 * k +: 8] == END_MARK) e[8 * k +: 8] = 8'h7D;
    return e;
  endfunction

  function automatic logic [EPC_W-1:0] fresh_epc();
    return clean_epc({$urandom, $urandom, $urandom});
  endfunction

  function automatic logic [EPC_W-1:0] pick_epc();
    logic [EPC_W-1:0] e;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && epc_pool.size() > 0) return epc_pool[$urandom_range(0, epc_pool.size() - 1)];
    if (r < 40) return '0;
    if (r < 45) return '1;
    if (r < 50) begin
      // bytes right next to the end marker
      for (int k = 0; k < EPC_BYTES; k++) e[8 * k +: 8] = $urandom_range(0, 1) ? 8'h7D : 8'h7F;
      return e;
    end
    return fresh_epc();
  endfunction

  task automatic send_good_frame(input logic [EPC_W-1:0] epc);
    send_frame(epc, FLAW_NONE, FRAME_BYTES);
    epc_pool.push_back(epc);
    if (epc_pool.size() > MAX_TAGS) void'(epc_pool.pop_front());
  endtask

  initial begin
    int pick;
    int mark;
    bit fill_done;
    logic [7:0] noise;
    fill_done = 1'b0;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // a frame straight out of reset, then a clear whose data byte must be ignored
    send_good_frame('1);
    send_item(KIND_CLEAR, 8'hFF);

    while (item_count - fill_items < RANDOM_ITEMS) begin
      if (!fill_done && item_count >= FILL_AFTER) begin
        // fill the store, then push past it with new and known tags
        mark = item_count;
        while (tracker.stored < MAX_TAGS) send_good_frame(fresh_epc());
        repeat (4) send_good_frame(fresh_epc());
        repeat (4) send_good_frame(epc_pool[$urandom_range(0, epc_pool.size() - 1)]);
        fill_items = item_count - mark;
        fill_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_good_frame(pick_epc());
        end else if (pick < 63) begin
          send_frame(pick_epc(), frame_flaw_t'($urandom_range(1, 3)), FRAME_BYTES);
        end else if (pick < 71) begin
          send_frame(pick_epc(), FLAW_NONE, $urandom_range(1, FRAME_BYTES - 1));
        end else if (pick < 97) begin
          repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 5))
              0: noise = HDR_START;
              1: noise = HDR_TYPE;
              2: noise = HDR_CMD;
              3: noise = END_MARK;
              default: noise = 8'($urandom_range(0, 255));
            endcase
            send_item(KIND_BYTE, noise);
          end
        end else begin
          send_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
        end
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
